[hw/rtl/bpfm_pkg.sv]
// Shared constants for the byte pattern first-match search.
// Used by bpfm_cell and byte_pattern_first_match.
package bpfm_pkg;

  localparam int MAX_PATTERN_DEF   = 32;
  localparam int POSITION_BITS_DEF = 32;

  localparam int BYTE_BITS      = 8;
  localparam int LEN_REG_BITS   = 6;
  localparam int WORD_BITS      = 64;
  localparam int PATTERN_WORDS  = 4;
  localparam int PATTERN_BYTES  = PATTERN_WORDS * (WORD_BITS / BYTE_BITS);
  localparam int ADDR_BITS      = 48;
  localparam int OFFSET_BITS    = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_BASE     = 3'd5;

endpackage

[hw/rtl/byte_pattern_first_match.sv]
// Streams the bytes of one memory range and reports the first offset at which
// a configured pattern of 1 to MAX_PATTERN bytes occurs. The block takes one
// byte per clock cycle; that figure is set by the row of window cells, each of
// which compares its incoming byte with its pattern byte in the same cycle the
// byte shifts in, followed by one AND across the row. The item carrying
// last_byte loads the output register at the edge that accepts it, so its
// result is offered in the next cycle; a new range may start in that cycle as
// the result is taken, and while out_stall holds the result the byte input
// stalls. The user must write configuration only while no range is in
// progress; the block itself does not enforce it. Uses bpfm_pkg and bpfm_cell.
module byte_pattern_first_match #(
  parameter int MAX_PATTERN   = bpfm_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = bpfm_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpfm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bpfm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // byte stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bpfm_pkg::BYTE_BITS-1:0]      data_byte,
  input  logic                                last_byte,
  // result
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [bpfm_pkg::OFFSET_BITS-1:0]    match_offset,
  output logic [bpfm_pkg::ADDR_BITS-1:0]      match_address
);

  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // configuration registers
  logic [bpfm_pkg::LEN_REG_BITS-1:0]                        pattern_len;
  logic [bpfm_pkg::PATTERN_WORDS-1:0][bpfm_pkg::WORD_BITS-1:0] pattern_word;
  logic [bpfm_pkg::ADDR_BITS-1:0]                           range_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= bpfm_pkg::LEN_REG_BITS'(1);
      pattern_word <= '0;
      range_base   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpfm_pkg::REG_PATTERN_LEN:
          pattern_len <= cfg_data[bpfm_pkg::LEN_REG_BITS-1:0];
        bpfm_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        bpfm_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        bpfm_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        bpfm_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        bpfm_pkg::REG_RANGE_BASE:
          range_base <= cfg_data[bpfm_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to 1..MAX_PATTERN
  logic [LEN_BITS-1:0] len_eff;

  always_comb begin
    if (pattern_len == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (int'(pattern_len) > MAX_PATTERN) begin
      len_eff = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_eff = LEN_BITS'(pattern_len);
    end
  end

  // pattern bytes; bytes past the four words read as zero
  logic [bpfm_pkg::BYTE_BITS-1:0] pat_arr [MAX_PATTERN];

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < bpfm_pkg::PATTERN_BYTES) begin : g_word
      assign pat_arr[k] =
        pattern_word[k >> 3][bpfm_pkg::BYTE_BITS*(k & 7) +: bpfm_pkg::BYTE_BITS];
    end else begin : g_zero
      assign pat_arr[k] = '0;
    end
  end

  // handshake
  logic advance;

  assign in_stall = out_valid && out_stall;
  assign advance  = in_valid && !in_stall;

  // row of window cells; cell i holds the byte i positions back
  logic [bpfm_pkg::BYTE_BITS-1:0] chain [MAX_PATTERN+1];
  logic [bpfm_pkg::BYTE_BITS-1:0] pat_sel [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]         in_use;
  logic [MAX_PATTERN-1:0]         hit_vec;

  assign chain[0] = data_byte;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    // cell i lines up with pattern byte len - 1 - i
    always_comb begin
      pat_sel[i] = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (k + i + 1 == int'(len_eff)) begin
          pat_sel[i] = pat_arr[k];
        end
      end
    end

    assign in_use[i] = i < int'(len_eff);

    bpfm_cell u_cell (
      .clk      (clk),
      .advance  (advance),
      .shift_in (chain[i]),
      .pat_byte (pat_sel[i]),
      .in_use   (in_use[i]),
      .byte_out (chain[i+1]),
      .hit      (hit_vec[i])
    );
  end

  // scan state
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] pos_next;
  logic                     match_seen;
  logic [POSITION_BITS-1:0] first_offset;
  logic                     hit_now;
  logic [POSITION_BITS-1:0] off_now;
  logic [POSITION_BITS-1:0] off_sel;
  logic                     found_now;

  always_comb begin
    pos_next  = (byte_position != POS_MAX) ? byte_position + 1'b1 : byte_position;
    hit_now   = !match_seen && (pos_next >= POSITION_BITS'(len_eff)) && (&hit_vec);
    off_now   = pos_next - POSITION_BITS'(len_eff);
    off_sel   = match_seen ? first_offset : off_now;
    found_now = match_seen || hit_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_seen    <= 1'b0;
      first_offset  <= '0;
    end else if (advance) begin
      if (last_byte) begin
        // range done: clear for the next one
        byte_position <= '0;
        match_seen    <= 1'b0;
        first_offset  <= '0;
      end else begin
        byte_position <= pos_next;
        if (hit_now) begin
          match_seen   <= 1'b1;
          first_offset <= off_now;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_byte) begin
      found <= found_now;
      if (found_now) begin
        match_offset  <= bpfm_pkg::OFFSET_BITS'(off_sel);
        match_address <= range_base + bpfm_pkg::ADDR_BITS'(off_sel);
      end else begin
        match_offset  <= '0;
        match_address <= '0;
      end
    end
  end

endmodule

[hw/rtl/bpfm_cell.sv]
// One window cell: holds one byte of the recent-byte window and compares
// the byte entering it with its aligned pattern byte. Uses bpfm_pkg.
module bpfm_cell (
  input  logic                           clk,
  input  logic                           advance,
  input  logic [bpfm_pkg::BYTE_BITS-1:0] shift_in,
  input  logic [bpfm_pkg::BYTE_BITS-1:0] pat_byte,
  input  logic                           in_use,
  output logic [bpfm_pkg::BYTE_BITS-1:0] byte_out,
  output logic                           hit
);

  logic [bpfm_pkg::BYTE_BITS-1:0] held;

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= shift_in;
    end
  end

  assign byte_out = held;

  // The incoming byte is this cell's window content after the shift
  assign hit = !in_use || (shift_in == pat_byte);

endmodule

[bench/byte_pattern_first_match_tb.sv]
// Self-checking testbench for byte_pattern_first_match: streams byte ranges,
// predicts the first-match report of each range and checks every result.
// Depends on bpfm_pkg and the byte_pattern_first_match RTL.
`timescale 1ns / 1ps

module byte_pattern_first_match_tb;
  import bpfm_pkg::*;

  localparam int MAX_PAT       = MAX_PATTERN_DEF;
  localparam int POS_BITS      = POSITION_BITS_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 420;
  localparam int CALM_BYTES    = 70;

  // indexes the block has no register for
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [BYTE_BITS-1:0] b;
    logic                 last;
  } stream_item_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
    logic [ADDR_BITS-1:0]   address;
  } match_report_t;

  logic clk;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [BYTE_BITS-1:0] data_byte = '0;
  logic                 last_byte = 1'b0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   found;
  logic [OFFSET_BITS-1:0] match_offset;
  logic [ADDR_BITS-1:0]   match_address;

  // configuration as the block should hold it
  logic [LEN_REG_BITS-1:0] cfg_pat_len = LEN_REG_BITS'(1);
  logic [WORD_BITS-1:0]    cfg_words [PATTERN_WORDS] = '{default: '0};
  logic [ADDR_BITS-1:0]    cfg_base = '0;

  // search state of the predictor
  logic [BYTE_BITS-1:0] window [MAX_PAT] = '{default: '0};
  logic [POS_BITS-1:0]  byte_count = '0;
  logic                 seen = 1'b0;
  logic [POS_BITS-1:0]  first_off = '0;

  stream_item_t  byte_feed [$];
  match_report_t pending_reports [$];

  int unsigned bytes_made  = 0;
  int unsigned bytes_taken = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          calm = 1'b0;

  byte_pattern_first_match #(
    .MAX_PATTERN  (MAX_PAT),
    .POSITION_BITS(POS_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_offset (match_offset),
    .match_address(match_address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned used_len();
    if (cfg_pat_len == 0) return 1;
    if (cfg_pat_len > MAX_PAT) return MAX_PAT;
    return cfg_pat_len;
  endfunction

  function automatic logic [BYTE_BITS-1:0] pat_byte(input int unsigned k);
    if (k >= PATTERN_BYTES) return '0;
    return cfg_words[k / 8][8 * (k % 8) +: 8];
  endfunction

  // Shift one byte into the window, look for the first match and, on the
  // final byte of a range, queue its report and clear the search.
  function automatic void scan_byte(input logic [BYTE_BITS-1:0] b, input logic last);
    int unsigned   n;
    logic          hit;
    logic [ADDR_BITS-1:0] off_wide;
    match_report_t rep;
    n = used_len();
    for (int i = MAX_PAT - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = b;
    if (byte_count != '1) byte_count++;
    if (!seen && byte_count >= n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++)
        if (pat_byte(i) != window[n - 1 - i]) hit = 1'b0;
      if (hit) begin
        seen = 1'b1;
        first_off = byte_count - n;
      end
    end
    if (last) begin
      rep = '0;
      if (seen) begin
        off_wide    = first_off;
        rep.found   = 1'b1;
        rep.offset  = first_off[OFFSET_BITS-1:0];
        rep.address = cfg_base + off_wide;
      end
      pending_reports.push_back(rep);
      window     = '{default: '0};
      byte_count = '0;
      seen       = 1'b0;
      first_off  = '0;
    end
  endfunction

  function automatic void feed(input logic [BYTE_BITS-1:0] b, input logic last);
    stream_item_t it;
    it.b    = b;
    it.last = last;
    byte_feed.push_back(it);
    bytes_made++;
  endfunction

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic set_register(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LEN:    cfg_pat_len  = val[LEN_REG_BITS-1:0];
      REG_PATTERN_WORD_0: cfg_words[0] = val;
      REG_PATTERN_WORD_1: cfg_words[1] = val;
      REG_PATTERN_WORD_2: cfg_words[2] = val;
      REG_PATTERN_WORD_3: cfg_words[3] = val;
      REG_RANGE_BASE:     cfg_base     = val[ADDR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_search(input logic [CFG_DATA_BITS-1:0] len_val,
                             input logic [CFG_DATA_BITS-1:0] w0,
                             input logic [CFG_DATA_BITS-1:0] w1,
                             input logic [CFG_DATA_BITS-1:0] w2,
                             input logic [CFG_DATA_BITS-1:0] w3,
                             input logic [CFG_DATA_BITS-1:0] base,
                             input bit spare);
    if (spare) set_register(REG_SPARE_6, {$urandom, $urandom});
    set_register(REG_PATTERN_LEN, len_val);
    set_register(REG_PATTERN_WORD_0, w0);
    set_register(REG_PATTERN_WORD_1, w1);
    set_register(REG_PATTERN_WORD_2, w2);
    set_register(REG_PATTERN_WORD_3, w3);
    set_register(REG_RANGE_BASE, base);
    if (spare) set_register(REG_SPARE_7, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Hold until every byte is taken and every report has come back.
  task automatic wait_quiet();
    while (bytes_taken != bytes_made || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_bytes
    stream_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(data_byte, last_byte);
        bytes_taken++;
      end
      if (calm) send_gap = 0;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || byte_feed.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          nxt = byte_feed.pop_front();
          in_valid  <= 1'b1;
          data_byte <= nxt.b;
          last_byte <= nxt.last;
          if (!calm && $urandom_range(0, 99) < send_idle_pct)
            send_gap = $urandom_range(1, 10);
        end
      end
    end
  end

  always @(posedge clk) begin : check_reports
    match_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result: found %0d match_offset 0x%0h match_address 0x%0h",
                 found, match_offset, match_address);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors++;
          end
          if (match_offset !== want.offset) begin
            $error("match_offset: expected 0x%0h, actual 0x%0h", want.offset, match_offset);
            errors++;
          end
          if (match_address !== want.address) begin
            $error("match_address: expected 0x%0h, actual 0x%0h",
                   want.address, match_address);
            errors++;
          end
        end
      end
      if (calm) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_BITS-1:0] len_val;
    logic [CFG_DATA_BITS-1:0] base;
    logic [CFG_DATA_BITS-1:0] w [PATTERN_WORDS];
    logic [BYTE_BITS-1:0]     chunk [$];
    int unsigned eff, n, at, mode, ranges, stop_at, p;
    bit plant;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one pattern byte of zero, base zero
    feed(8'h00, 1'b1);
    feed(8'hFF, 1'b0);
    feed(8'h00, 1'b1);
    feed(8'hFF, 1'b1);
    wait_quiet();

    // three-byte pattern, base at the top of the address space so it wraps;
    // upper bits of the length write must be dropped
    load_search(64'hFFFF_FFFF_FFFF_FFC3, 64'h0000_0000_00CC_BBAA, '0, '0, '0, '1, 1'b1);
    feed(8'hAA, 1'b0);
    feed(8'hBB, 1'b1);
    feed(8'h11, 1'b0);
    feed(8'hAA, 1'b0);
    feed(8'hBB, 1'b0);
    feed(8'hCC, 1'b0);
    feed(8'hAA, 1'b0);
    feed(8'hBB, 1'b0);
    feed(8'hCC, 1'b1);
    feed(8'hAA, 1'b0);
    feed(8'hBB, 1'b0);
    feed(8'hCC, 1'b1);
    wait_quiet();

    // length zero behaves as one
    load_search('0, 64'h0000_0000_0000_00FF, '1, '1, '1, '0, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b1);
    wait_quiet();

    stop_at = bytes_made + RANDOM_BYTES;
    p = 0;
    while (bytes_made < stop_at) begin
      calm = (bytes_made + CALM_BYTES >= stop_at);
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 50;
      endcase

      len_val = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: len_val[5:0] = 6'd0;
        1: len_val[5:0] = 6'd32;
        2: len_val[5:0] = 6'($urandom_range(33, 63));
        3, 4: len_val[5:0] = 6'($urandom_range(1, 3));
        5: len_val[5:0] = 6'($urandom_range(13, 31));
        default: len_val[5:0] = 6'($urandom_range(1, 12));
      endcase
      foreach (w[i]) w[i] = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: base = '1;
        1: base = '0;
        2: base = 64'h0000_FFFF_FFFF_FFF0;
        default: base = {$urandom, $urandom};
      endcase
      // force the widest pattern early, once through an oversized length
      if (p == 0) begin
        len_val[5:0] = 6'd63;
        base = '1;
      end
      if (p == 1) begin
        len_val[5:0] = 6'd32;
        foreach (w[i]) w[i] = '1;
        base = '0;
      end
      load_search(len_val, w[0], w[1], w[2], w[3], base, $urandom_range(0, 3) == 0);

      eff    = used_len();
      ranges = $urandom_range(6, 12);
      for (int r = 0; r < ranges; r++) begin
        // end the group at the byte budget, or where the quiet tail begins
        if (bytes_made >= stop_at || (!calm && bytes_made + CALM_BYTES >= stop_at)) break;
        case ($urandom_range(0, 9))
          0: n = $urandom_range(1, eff);
          1: n = eff + $urandom_range(20, 40);
          default: n = $urandom_range(eff, eff + 8);
        endcase
        plant = ($urandom_range(0, 3) != 0);
        mode  = $urandom_range(0, 2);
        chunk.delete();
        for (int k = 0; k < n; k++) begin
          case (mode)
            0: chunk.push_back(8'($urandom));
            1: chunk.push_back(pat_byte($urandom_range(0, eff - 1)));
            // near copies of the pattern with a few bytes disturbed
            default: chunk.push_back(pat_byte(k % eff) ^
                       (($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00));
          endcase
        end
        if (plant && n >= eff) begin
          at = $urandom_range(0, n - eff);
          for (int k = 0; k < eff; k++) chunk[at + k] = pat_byte(k);
        end
        for (int k = 0; k < n; k++) feed(chunk[k], k == n - 1);
      end
      wait_quiet();
      p++;
    end

    wait_quiet();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bpfm_pkg.sv
hw/rtl/bpfm_cell.sv
hw/rtl/byte_pattern_first_match.sv
bench/byte_pattern_first_match_tb.sv
